### sv/gse_pkg.sv
package gse_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_SIZE   = 5;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int EW_W  = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int EH_W  = $clog2(MAX_HEIGHT + 1);

  localparam int PIX_W    = 8;
  localparam int SM_W     = 12;
  localparam int GRAD_W   = 14;
  localparam int SQ_W     = 2 * GRAD_W;
  localparam int MAG_W    = 29;
  localparam int THR_W    = 15;
  localparam int THR_SQ_W = 2 * THR_W;

  localparam int RAW_WORD_W = 2 * PIX_W;
  localparam int SM_WORD_W  = 2 * SM_W;

  localparam int CFG_W_W    = 11;
  localparam int CFG_H_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

  localparam int RESET_WIDTH     = 640;
  localparam int RESET_HEIGHT    = 480;
  localparam int RESET_THRESHOLD = 0;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             bank;
    logic             smooth_en;
    logic             out_en;
    logic             last;
  } gse_tag_t;

  typedef struct packed {
    gse_tag_t        tag;
    logic [SM_W-1:0] smooth;
  } gse_item_t;

  typedef struct packed {
    logic             edge_res;
    logic [MAG_W-1:0] magnitude_sq;
    logic             last_of_frame;
  } gse_result_t;

  typedef struct packed {
    logic [EW_W-1:0]     width;
    logic [EH_W-1:0]     height;
    logic [THR_SQ_W-1:0] thr_sq;
  } gse_cfg_t;

endpackage

### sv/gse_if.sv
interface gse_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [gse_pkg::PIX_W-1:0]  pixel;
  logic                       start_of_frame;

  modport source (output valid, pixel, start_of_frame, input ready);
  modport sink (input valid, pixel, start_of_frame, output ready);
endinterface

interface gse_result_if;
  logic                       valid;
  logic                       ready;
  logic                       edge_res;
  logic [gse_pkg::MAG_W-1:0]  magnitude_sq;
  logic                       last_of_frame;

  modport source (output valid, edge_res, magnitude_sq, last_of_frame, input ready);
  modport sink (input valid, edge_res, magnitude_sq, last_of_frame, output ready);
endinterface

interface gse_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gse_pkg::CFG_IDX_W-1:0]   index;
  logic [gse_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/gse_ram.sv
module gse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/gse_front.sv
module gse_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      accept,
  input  logic [gse_pkg::PIX_W-1:0] pixel,
  input  logic                      start_of_frame,
  input  gse_pkg::gse_cfg_t         cfg_eff,
  output logic                      item_valid,
  output gse_pkg::gse_item_t        item
);

  localparam int P = gse_pkg::PIX_W;

  logic [gse_pkg::COL_W-1:0] col_cnt;
  logic [gse_pkg::ROW_W-1:0] row_cnt;
  logic [gse_pkg::EW_W-1:0]  c_at, c_next;
  logic [gse_pkg::EH_W-1:0]  r_at, r_next;
  gse_pkg::gse_tag_t         tag_at;

  logic                              s1_valid;
  gse_pkg::gse_tag_t                 s1_tag;
  logic [P-1:0]                      s1_px;
  logic                              raw_fwd;
  logic [gse_pkg::RAW_WORD_W-1:0]    raw_fwd_data;
  logic [gse_pkg::RAW_WORD_W-1:0]    raw_rdata, raw_word, raw_wdata;
  logic [P-1:0]                      row_top, row_mid;

  logic [P-1:0]              raw_win [3][3];
  logic                      s2_valid;
  gse_pkg::gse_tag_t         s2_tag;
  logic [gse_pkg::SM_W-1:0]  gauss;

  // Position of this pixel, then the position of the next one.
  always_comb begin
    c_at = start_of_frame ? '0 : gse_pkg::EW_W'(col_cnt);
    r_at = start_of_frame ? '0 : gse_pkg::EH_W'(row_cnt);
    if (c_at >= cfg_eff.width) begin
      c_at = '0;
      r_at = r_at + gse_pkg::EH_W'(1);
    end
    if (r_at >= cfg_eff.height) begin
      r_at = '0;
    end
    c_next = c_at + gse_pkg::EW_W'(1);
    r_next = r_at;
    if (c_next >= cfg_eff.width) begin
      c_next = '0;
      r_next = r_at + gse_pkg::EH_W'(1);
      if (r_next >= cfg_eff.height) begin
        r_next = '0;
      end
    end
    tag_at.col       = c_at[gse_pkg::COL_W-1:0];
    tag_at.bank      = r_at[0];
    tag_at.smooth_en = (r_at >= 2) && (c_at >= 2);
    tag_at.out_en    = (r_at >= 4) && (c_at >= 4);
    tag_at.last      = (r_at == cfg_eff.height - gse_pkg::EH_W'(1)) &&
                       (c_at == cfg_eff.width - gse_pkg::EW_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      col_cnt <= c_next[gse_pkg::COL_W-1:0];
      row_cnt <= r_next[gse_pkg::ROW_W-1:0];
    end
  end

  // Each word holds both stored rows of one column; the row parity picks the half.
  gse_ram #(
    .WIDTH (gse_pkg::RAW_WORD_W),
    .DEPTH (gse_pkg::MAX_WIDTH)
  ) u_raw_ram (
    .clk   (clk),
    .we    (en && s1_valid),
    .waddr (s1_tag.col),
    .wdata (raw_wdata),
    .re    (accept),
    .raddr (tag_at.col),
    .rdata (raw_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      raw_fwd  <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
      raw_fwd  <= accept && s1_valid && (s1_tag.col == tag_at.col);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tag       <= tag_at;
      s1_px        <= pixel;
      raw_fwd_data <= raw_wdata;
    end
  end

  // A request to the column that was written in the same cycle takes the written word.
  always_comb begin
    raw_word = raw_fwd ? raw_fwd_data : raw_rdata;
    if (s1_tag.bank) begin
      row_top   = raw_word[2*P-1:P];
      row_mid   = raw_word[P-1:0];
      raw_wdata = {s1_px, raw_word[P-1:0]};
    end else begin
      row_top   = raw_word[P-1:0];
      row_mid   = raw_word[2*P-1:P];
      raw_wdata = {raw_word[2*P-1:P], s1_px};
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      for (int i = 0; i < 3; i++) begin
        raw_win[i][0] <= raw_win[i][1];
        raw_win[i][1] <= raw_win[i][2];
      end
      raw_win[0][2] <= row_top;
      raw_win[1][2] <= row_mid;
      raw_win[2][2] <= s1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid   <= 1'b0;
      item_valid <= 1'b0;
    end else if (en) begin
      s2_valid   <= s1_valid;
      item_valid <= s2_valid && s2_tag.smooth_en;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_tag      <= s1_tag;
      item.tag    <= s2_tag;
      item.smooth <= gauss;
    end
  end

  always_comb begin
    gauss = gse_pkg::SM_W'(raw_win[0][0]) + gse_pkg::SM_W'(raw_win[0][2]) +
            gse_pkg::SM_W'(raw_win[2][0]) + gse_pkg::SM_W'(raw_win[2][2]) +
            ((gse_pkg::SM_W'(raw_win[0][1]) + gse_pkg::SM_W'(raw_win[1][0]) +
              gse_pkg::SM_W'(raw_win[1][2]) + gse_pkg::SM_W'(raw_win[2][1])) << 1) +
            (gse_pkg::SM_W'(raw_win[1][1]) << 2);
  end

  a_sof_origin: assert property (@(posedge clk) disable iff (rst)
    (accept && start_of_frame) |=> (s1_valid && (s1_tag.col == '0) && !s1_tag.bank))
    else $error("start of frame did not land on row 0, column 0");

  a_raw_fwd_item: assert property (@(posedge clk) disable iff (rst)
    raw_fwd |-> s1_valid)
    else $error("raw forwarding flagged without an item in the first stage");

endmodule

### sv/gse_back.sv
module gse_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  gse_pkg::gse_item_t    item,
  input  gse_pkg::gse_cfg_t     cfg_eff,
  input  logic                  out_ready,
  output logic                  en,
  output logic                  out_valid,
  output gse_pkg::gse_result_t  result
);

  localparam int S = gse_pkg::SM_W;

  logic [gse_pkg::COL_W-1:0]      sc_at;
  logic                           b1_valid;
  gse_pkg::gse_tag_t              b1_tag;
  logic [S-1:0]                   b1_smooth;
  logic [gse_pkg::COL_W-1:0]      b1_sc;
  logic                           sm_fwd;
  logic [gse_pkg::SM_WORD_W-1:0]  sm_fwd_data;
  logic [gse_pkg::SM_WORD_W-1:0]  sm_rdata, sm_word, sm_wdata;
  logic [S-1:0]                   sm_top, sm_mid;

  logic [S-1:0]                   sm_win [3][3];
  logic                           b2_valid, b2_last;
  logic [gse_pkg::GRAD_W-1:0]     gx_pos, gx_neg, gy_pos, gy_neg, gx_abs, gy_abs;
  logic                           b3_valid, b3_last;
  logic [gse_pkg::GRAD_W-1:0]     b3_gx, b3_gy;
  logic                           b4_valid, b4_last;
  logic [gse_pkg::SQ_W-1:0]       sq_x, sq_y;
  logic [gse_pkg::MAG_W-1:0]      mag;
  logic                           over;

  // The pipeline holds only when a new result meets a result that is still waiting.
  assign en    = !(b4_valid && out_valid && !out_ready);
  assign sc_at = item.tag.col - gse_pkg::COL_W'(2);

  gse_ram #(
    .WIDTH (gse_pkg::SM_WORD_W),
    .DEPTH (gse_pkg::MAX_WIDTH)
  ) u_smooth_ram (
    .clk   (clk),
    .we    (en && b1_valid),
    .waddr (b1_sc),
    .wdata (sm_wdata),
    .re    (en && item_valid),
    .raddr (sc_at),
    .rdata (sm_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      sm_fwd   <= 1'b0;
      b2_valid <= 1'b0;
      b3_valid <= 1'b0;
      b4_valid <= 1'b0;
    end else if (en) begin
      b1_valid <= item_valid;
      sm_fwd   <= item_valid && b1_valid && (b1_sc == sc_at);
      b2_valid <= b1_valid && b1_tag.out_en;
      b3_valid <= b2_valid;
      b4_valid <= b3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_tag      <= item.tag;
      b1_smooth   <= item.smooth;
      b1_sc       <= sc_at;
      sm_fwd_data <= sm_wdata;
      b2_last     <= b1_tag.last;
      b3_last     <= b2_last;
      b3_gx       <= gx_abs;
      b3_gy       <= gy_abs;
      b4_last     <= b3_last;
      sq_x        <= gse_pkg::SQ_W'(b3_gx) * gse_pkg::SQ_W'(b3_gx);
      sq_y        <= gse_pkg::SQ_W'(b3_gy) * gse_pkg::SQ_W'(b3_gy);
    end
  end

  always_comb begin
    sm_word = sm_fwd ? sm_fwd_data : sm_rdata;
    if (b1_tag.bank) begin
      sm_top   = sm_word[2*S-1:S];
      sm_mid   = sm_word[S-1:0];
      sm_wdata = {b1_smooth, sm_word[S-1:0]};
    end else begin
      sm_top   = sm_word[S-1:0];
      sm_mid   = sm_word[2*S-1:S];
      sm_wdata = {sm_word[2*S-1:S], b1_smooth};
    end
  end

  always_ff @(posedge clk) begin
    if (en && b1_valid) begin
      for (int i = 0; i < 3; i++) begin
        sm_win[i][0] <= sm_win[i][1];
        sm_win[i][1] <= sm_win[i][2];
      end
      sm_win[0][2] <= sm_top;
      sm_win[1][2] <= sm_mid;
      sm_win[2][2] <= b1_smooth;
    end
  end

  // Each gradient is split into its positive and negative taps, so only magnitudes remain.
  always_comb begin
    gx_pos = gse_pkg::GRAD_W'(sm_win[0][2]) + (gse_pkg::GRAD_W'(sm_win[1][2]) << 1) +
             gse_pkg::GRAD_W'(sm_win[2][2]);
    gx_neg = gse_pkg::GRAD_W'(sm_win[0][0]) + (gse_pkg::GRAD_W'(sm_win[1][0]) << 1) +
             gse_pkg::GRAD_W'(sm_win[2][0]);
    gy_pos = gse_pkg::GRAD_W'(sm_win[2][0]) + (gse_pkg::GRAD_W'(sm_win[2][1]) << 1) +
             gse_pkg::GRAD_W'(sm_win[2][2]);
    gy_neg = gse_pkg::GRAD_W'(sm_win[0][0]) + (gse_pkg::GRAD_W'(sm_win[0][1]) << 1) +
             gse_pkg::GRAD_W'(sm_win[0][2]);
    gx_abs = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
    gy_abs = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
  end

  always_comb begin
    mag  = gse_pkg::MAG_W'(sq_x) + gse_pkg::MAG_W'(sq_y);
    over = gse_pkg::THR_SQ_W'(mag) > cfg_eff.thr_sq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && b4_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && b4_valid) begin
      result.edge_res      <= over;
      result.magnitude_sq  <= mag;
      result.last_of_frame <= b4_last;
    end
  end

  a_sm_fwd_item: assert property (@(posedge clk) disable iff (rst)
    sm_fwd |-> b1_valid)
    else $error("smooth forwarding flagged without an item in its stage");

  a_smooth_col: assert property (@(posedge clk) disable iff (rst)
    item_valid |-> (item.tag.col >= 2))
    else $error("smoothed item arrived from a column left of the window");

  a_out_needs_smooth: assert property (@(posedge clk) disable iff (rst)
    (b1_valid && b1_tag.out_en) |-> b1_tag.smooth_en)
    else $error("result flagged for a pixel without a smoothed value");

endmodule

### sv/gauss_sobel_edge_detector_top.sv
// One pixel is accepted per clock; the block takes a new pixel every cycle unless intake halts.
// A result passes the front registers s1, s2 and item, then the back registers b1 to b4 and the output register.
// Intake halts while a result waits at the output and the next one is ready behind it,
// and in the cycle after a register write while the clamped sizes settle.
// Reset (synchronous) zeroes the row and column counters and loads width 640, height 480,
// threshold 0; the line stores are not cleared and fill from the first two rows of a frame.
module gauss_sobel_edge_detector_top (
  input  logic         clk,
  input  logic         rst,
  gse_pixel_if.sink    pixels,
  gse_result_if.source results,
  gse_cfg_if.sink      cfg
);

  logic [gse_pkg::CFG_W_W-1:0] image_width;
  logic [gse_pkg::CFG_H_W-1:0] image_height;
  logic [gse_pkg::THR_W-1:0]   edge_threshold;
  gse_pkg::gse_cfg_t           cfg_eff, cfg_eff_next;
  logic                        cfg_hold;

  logic                  en;
  logic                  accept;
  logic                  item_valid;
  gse_pkg::gse_item_t    item;
  logic                  out_valid;
  gse_pkg::gse_result_t  result;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= gse_pkg::CFG_W_W'(gse_pkg::RESET_WIDTH);
      image_height   <= gse_pkg::CFG_H_W'(gse_pkg::RESET_HEIGHT);
      edge_threshold <= gse_pkg::THR_W'(gse_pkg::RESET_THRESHOLD);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        gse_pkg::REG_IMAGE_WIDTH:    image_width    <= cfg.data[gse_pkg::CFG_W_W-1:0];
        gse_pkg::REG_IMAGE_HEIGHT:   image_height   <= cfg.data[gse_pkg::CFG_H_W-1:0];
        gse_pkg::REG_EDGE_THRESHOLD: edge_threshold <= cfg.data[gse_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Sizes are clamped to the supported range and the threshold is squared once here.
  always_comb begin
    if (image_width < gse_pkg::MIN_SIZE) begin
      cfg_eff_next.width = gse_pkg::EW_W'(gse_pkg::MIN_SIZE);
    end else if (image_width > gse_pkg::MAX_WIDTH) begin
      cfg_eff_next.width = gse_pkg::EW_W'(gse_pkg::MAX_WIDTH);
    end else begin
      cfg_eff_next.width = gse_pkg::EW_W'(image_width);
    end
    if (image_height < gse_pkg::MIN_SIZE) begin
      cfg_eff_next.height = gse_pkg::EH_W'(gse_pkg::MIN_SIZE);
    end else if (image_height > gse_pkg::MAX_HEIGHT) begin
      cfg_eff_next.height = gse_pkg::EH_W'(gse_pkg::MAX_HEIGHT);
    end else begin
      cfg_eff_next.height = gse_pkg::EH_W'(image_height);
    end
    cfg_eff_next.thr_sq = gse_pkg::THR_SQ_W'(edge_threshold) *
                          gse_pkg::THR_SQ_W'(edge_threshold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_eff.width  <= gse_pkg::EW_W'(gse_pkg::RESET_WIDTH);
      cfg_eff.height <= gse_pkg::EH_W'(gse_pkg::RESET_HEIGHT);
      cfg_eff.thr_sq <= '0;
    end else begin
      cfg_eff <= cfg_eff_next;
    end
  end

  // The clamped settings reach cfg_eff in the cycle after a register write, so the next pixel waits for them.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_hold <= 1'b0;
    end else begin
      cfg_hold <= cfg.valid;
    end
  end

  assign pixels.ready = en && !cfg_hold;
  assign accept       = pixels.valid && pixels.ready;

  gse_front u_front (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .accept         (accept),
    .pixel          (pixels.pixel),
    .start_of_frame (pixels.start_of_frame),
    .cfg_eff        (cfg_eff),
    .item_valid     (item_valid),
    .item           (item)
  );

  gse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .cfg_eff    (cfg_eff),
    .out_ready  (results.ready),
    .en         (en),
    .out_valid  (out_valid),
    .result     (result)
  );

  assign results.valid         = out_valid;
  assign results.edge_res      = result.edge_res;
  assign results.magnitude_sq  = result.magnitude_sq;
  assign results.last_of_frame = result.last_of_frame;

endmodule
